// ----- rtl/core/rbfe_pkg.sv -----
// ----------------------------------------------------------------------------
// rbfe_pkg: shared types and constants of the rbf grid estimator
// Grid geometry, fixed-point widths, register codes, the gaussian table and
// the command/status structs between controller and datapath.
// ----------------------------------------------------------------------------
package rbfe_pkg;

  // grid geometry
  localparam int GRID_SIDE = 36;
  localparam int NBHD      = 5;
  localparam int HALF      = (NBHD - 1) / 2;
  localparam int PI_Q      = 25736;
  localparam int CELLS     = GRID_SIDE * GRID_SIDE;
  localparam int MEM_DEPTH = 2 * CELLS;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);
  localparam int IDX_W     = $clog2(CELLS);
  localparam int ROW_W     = $clog2(GRID_SIDE);
  localparam int RR_W      = $clog2(GRID_SIDE + NBHD);
  localparam int NB_W      = $clog2(NBHD + 1);

  // port field widths
  localparam int ANGLE_A_W = 16;
  localparam int ANGLE_B_W = 15;
  localparam int ERR_W     = 32;
  localparam int FF_W      = 32;
  localparam int CELL_W    = 11;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 1;
  localparam int W_W       = 16;
  localparam int S_TDATA_W = 64;
  localparam int S_TUSER_W = 2;
  localparam int M_TDATA_W = 48;

  // register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] CFG_INV_WIDTH_SQ = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEARN_RATE   = 1'b1;
  localparam logic [CFG_W-1:0]     INV_WIDTH_SQ_RST = 16'd256;
  localparam logic [CFG_W-1:0]     LEARN_RATE_RST   = 16'd655;

  // item kinds
  localparam logic CMD_QUERY  = 1'b0;
  localparam logic CMD_UPDATE = 1'b1;

  // quantization: floor(x / PI_Q) as (x * QM) >> QS, exact for x < 2^QX_W
  localparam int QX_W = 22;
  localparam int QS   = 37;
  localparam int QM_W = 23;
  localparam logic [QM_W-1:0] QM = QM_W'(((64'd1 << QS) + PI_Q - 1) / PI_Q);
  localparam int QP_W = QX_W + QM_W;

  // distance and kernel index widths
  localparam int D_W     = 24;
  localparam int U_W     = D_W - 1;
  localparam int SQ_W    = 2 * U_W;
  localparam int S_W     = SQ_W + 1;
  localparam int SPLIT   = 24;
  localparam int Y_SHIFT = 29;
  localparam int Y_W     = $clog2(256 * CELLS);
  localparam int FAR_LIM = 256 * CELLS;
  localparam int KS      = 30;
  localparam longint unsigned KM_L = ((64'd1 << KS) + CELLS - 1) / CELLS;
  localparam int KM_W    = $clog2(KM_L + 1);
  localparam logic [KM_W-1:0] KM = KM_W'(KM_L);

  // accumulator and divider widths
  localparam int DEN_W      = $clog2(NBHD * NBHD * 65535 + 2);
  localparam int NUM_W      = DEN_W + 33;
  localparam int PIPE_DEPTH = 9;
  localparam int DIV_STEPS  = 16;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

  // gaussian table exp(-k/32) in Q0.16
  typedef logic [W_W-1:0] gauss_tab_t [256];

  function automatic gauss_tab_t gauss_build();
    logic [63:0] acc;
    logic [63:0] v;
    gauss_tab_t  t;
    acc = 64'h1_0000_0000;
    for (int k = 0; k < 256; k++) begin
      v = (acc + 64'd32768) >> 16;
      t[k] = (v > 64'd65535) ? 16'hFFFF : v[15:0];
      acc = (acc * 64'd4162825042 + 64'd2147483648) >> 32;
    end
    return t;
  endfunction

  localparam gauss_tab_t GAUSS_TAB = gauss_build();

  // controller to datapath
  typedef struct packed {
    logic              load;
    logic              issue;
    logic [NB_W-1:0]   ni;
    logic [NB_W-1:0]   nj;
    logic              div_start;
    logic              out_load;
    logic              clr_we;
    logic [ADDR_W-1:0] clr_addr;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_done;
  } dp_stat_t;

endpackage

// ----- rtl/core/rbfe_div.sv -----
// ----------------------------------------------------------------------------
// rbfe_div: iterative signed divider with 32-bit saturation
// Restoring division of the weighted sum by the weight sum, two quotient
// bits per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module rbfe_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic signed [rbfe_pkg::NUM_W-1:0] num,
  input  logic        [rbfe_pkg::DEN_W-1:0] den,
  output logic                              done,
  output logic signed [rbfe_pkg::FF_W-1:0]  quo
);
  import rbfe_pkg::*;

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 neg;
  logic                 sat;
  logic [DEN_W-1:0]     den_q;
  logic [DEN_W-1:0]     rem;
  logic [31:0]          sh;

  logic [NUM_W-2:0]     mag;
  logic [DEN_W:0]       t1;
  logic [DEN_W:0]       t2;
  logic                 ge1;
  logic                 ge2;
  logic [DEN_W-1:0]     r1;
  logic [DEN_W-1:0]     r2;
  logic signed [NUM_W-1:0] num_neg;

  // magnitude of the numerator
  assign num_neg = -num;
  assign mag = num[NUM_W-1] ? num_neg[NUM_W-2:0] : num[NUM_W-2:0];

  // two restoring steps
  always_comb begin
    t1  = {rem, sh[31]};
    ge1 = t1 >= {1'b0, den_q};
    r1  = ge1 ? DEN_W'(t1 - {1'b0, den_q}) : DEN_W'(t1);
    t2  = {r1, sh[30]};
    ge2 = t2 >= {1'b0, den_q};
    r2  = ge2 ? DEN_W'(t2 - {1'b0, den_q}) : DEN_W'(t2);
  end

  // iteration control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // operand and partial remainder registers
  always_ff @(posedge clk) begin
    if (start) begin
      neg   <= num[NUM_W-1];
      sat   <= mag[NUM_W-2:31] >= {1'b0, den};
      den_q <= den;
      rem   <= mag[NUM_W-2:32];
      sh    <= mag[31:0];
    end else if (busy) begin
      rem <= r2;
      sh  <= {sh[29:0], ge1, ge2};
    end
  end

  // signed, saturated quotient
  always_comb begin
    if (sat) begin
      quo = neg ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
    end else begin
      quo = neg ? -$signed(sh) : $signed(sh);
    end
  end

endmodule

// ----- rtl/core/rbfe_dp.sv -----
// ----------------------------------------------------------------------------
// rbfe_dp: datapath of the rbf grid estimator
// Angle quantization, the neighbour pipeline (distance, kernel index,
// gaussian weight, weight table read-modify-write or accumulate), the
// divider and the result register.
// ----------------------------------------------------------------------------
module rbfe_dp (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic        [rbfe_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic        [rbfe_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                                  in_upd,
  input  logic signed [rbfe_pkg::ANGLE_A_W-1:0] in_angle_a,
  input  logic        [rbfe_pkg::ANGLE_B_W-1:0] in_angle_b,
  input  logic                                  in_table_select,
  input  logic signed [rbfe_pkg::ERR_W-1:0]     in_err,
  input  rbfe_pkg::dp_cmd_t                     cmd,
  output rbfe_pkg::dp_stat_t                    stat,
  output logic signed [rbfe_pkg::FF_W-1:0]      ff_value,
  output logic        [rbfe_pkg::CELL_W-1:0]    cell_index
);
  import rbfe_pkg::*;

  localparam logic signed [D_W-1:0] GS_D    = D_W'(GRID_SIDE);
  localparam logic signed [D_W-1:0] PI_D    = D_W'(PI_Q);
  localparam logic signed [D_W-1:0] PI_GS_D = D_W'(PI_Q * GRID_SIDE);

  // item and configuration registers
  logic signed [ANGLE_A_W-1:0] a_q;
  logic        [ANGLE_B_W-1:0] b_q;
  logic                        sel_q;
  logic signed [ERR_W-1:0]     err_q;
  logic                        upd_q;
  logic        [CFG_W-1:0]     iw;
  logic        [CFG_W-1:0]     lr;

  // quantization
  logic signed [ANGLE_A_W:0]   xa_s;
  logic        [ANGLE_A_W-1:0] xa;
  logic        [QX_W-1:0]      xa_gs;
  logic        [QX_W-1:0]      xb_gs;
  logic        [QP_W-1:0]      qa_prod;
  logic        [QP_W-1:0]      qb_prod;
  logic        [QP_W-QS-1:0]   qa;
  logic        [QP_W-QS-1:0]   qb;
  logic        [ROW_W-1:0]     row;
  logic        [ROW_W-1:0]     col;

  // stage 0
  logic        [RR_W-1:0]      rr;
  logic        [RR_W-1:0]      cc;
  logic                        inr;
  logic        [ROW_W-1:0]     r_u;
  logic        [ROW_W-1:0]     c_u;
  logic        [IDX_W-1:0]     idx;
  logic        [ADDR_W-1:0]    raddr;
  logic signed [D_W-1:0]       da;
  logic signed [D_W-1:0]       db;
  logic signed [D_W-1:0]       da_n;
  logic signed [D_W-1:0]       db_n;

  // pipeline registers
  logic [8:1]                  v;
  logic [ADDR_W-1:0]           addr_p [1:8];
  logic signed [31:0]          rd_p   [1:8];
  logic [U_W-1:0]              ua1;
  logic [U_W-1:0]              ub1;
  logic [SQ_W-1:0]             sqa2;
  logic [SQ_W-1:0]             sqb2;
  logic [S_W-1:0]              s_sum;
  logic [S_W-SPLIT+CFG_W-1:0]  ph3;
  logic [SPLIT+CFG_W-1:0]      pl3;
  logic [S_W+CFG_W-1:0]        yfull;
  logic [S_W+CFG_W-Y_SHIFT-1:0] y_hi;
  logic [Y_W-1:0]              y4;
  logic                        far4;
  logic [Y_W+KM_W-1:0]         kprod;
  logic [7:0]                  k5;
  logic                        far5;
  logic [W_W-1:0]              w6;
  logic [W_W-1:0]              w7;
  logic signed [W_W+32:0]      prod7;
  logic [31:0]                 wl7;
  logic signed [64:0]          dprod8;

  // write-back
  logic signed [32:0]          delta;
  logic signed [33:0]          sum_new;
  logic signed [31:0]          new_val;
  logic                        mem_we;
  logic [ADDR_W-1:0]           waddr;
  logic signed [31:0]          wdata;
  logic signed [31:0]          mem [MEM_DEPTH];

  // accumulators and divider
  logic signed [NUM_W-1:0]     acc;
  logic [DEN_W-1:0]            accw;
  logic signed [FF_W-1:0]      quo;
  logic [IDX_W-1:0]            cidx;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      iw <= INV_WIDTH_SQ_RST;
      lr <= LEARN_RATE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_INV_WIDTH_SQ: iw <= cfg_wdata;
        CFG_LEARN_RATE:   lr <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a_q   <= in_angle_a;
      b_q   <= in_angle_b;
      sel_q <= in_table_select;
      err_q <= in_err;
      upd_q <= in_upd;
    end
  end

  // quantize angles to row and column
  assign xa_s  = $signed({a_q[ANGLE_A_W-1], a_q}) + $signed((ANGLE_A_W + 1)'(PI_Q));
  assign xa    = xa_s[ANGLE_A_W] ? '0 : xa_s[ANGLE_A_W-1:0];
  assign xa_gs = QX_W'(xa) * QX_W'(GRID_SIDE);
  assign xb_gs = QX_W'(b_q) * QX_W'(GRID_SIDE);
  assign qa    = qa_prod[QP_W-1:QS];
  assign qb    = qb_prod[QP_W-1:QS];

  always_ff @(posedge clk) begin
    qa_prod <= QP_W'(xa_gs) * QP_W'(QM);
    qb_prod <= QP_W'(xb_gs) * QP_W'(QM);
    row <= (qa > (QP_W-QS)'(GRID_SIDE - 1)) ? ROW_W'(GRID_SIDE - 1) : ROW_W'(qa);
    col <= (qb > (QP_W-QS)'(GRID_SIDE - 1)) ? ROW_W'(GRID_SIDE - 1) : ROW_W'(qb);
  end

  // stage 0: neighbour cell, address and distance to its centre
  always_comb begin
    rr    = RR_W'(row) + RR_W'(cmd.ni);
    cc    = RR_W'(col) + RR_W'(cmd.nj);
    inr   = (rr >= RR_W'(HALF)) && (rr <= RR_W'(GRID_SIDE - 1 + HALF)) &&
            (cc >= RR_W'(HALF)) && (cc <= RR_W'(GRID_SIDE - 1 + HALF));
    r_u   = ROW_W'(rr - RR_W'(HALF));
    c_u   = ROW_W'(cc - RR_W'(HALF));
    idx   = IDX_W'(r_u) * IDX_W'(GRID_SIDE) + IDX_W'(c_u);
    raddr = sel_q ? ADDR_W'(idx) + ADDR_W'(CELLS) : ADDR_W'(idx);
    da    = D_W'(a_q) * GS_D + PI_GS_D - $signed(D_W'(r_u)) * PI_D;
    db    = $signed(D_W'(b_q)) * GS_D - $signed(D_W'(c_u)) * PI_D;
    da_n  = -da;
    db_n  = -db;
  end

  // pipeline valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      v <= {v[7:1], cmd.issue & inr};
    end
  end

  // stage 1: absolute distances, address pipeline
  always_ff @(posedge clk) begin
    addr_p[1] <= raddr;
    ua1 <= da[D_W-1] ? da_n[U_W-1:0] : da[U_W-1:0];
    ub1 <= db[D_W-1] ? db_n[U_W-1:0] : db[U_W-1:0];
    for (int s = 2; s <= 8; s++) begin
      addr_p[s] <= addr_p[s-1];
    end
  end

  // stage 2: squares
  always_ff @(posedge clk) begin
    sqa2 <= SQ_W'(ua1) * SQ_W'(ua1);
    sqb2 <= SQ_W'(ub1) * SQ_W'(ub1);
  end

  // stage 3: squared distance times width register, in two partial products
  assign s_sum = S_W'(sqa2) + S_W'(sqb2);

  always_ff @(posedge clk) begin
    ph3 <= (S_W-SPLIT+CFG_W)'(s_sum[S_W-1:SPLIT]) * (S_W-SPLIT+CFG_W)'(iw);
    pl3 <= (SPLIT+CFG_W)'(s_sum[SPLIT-1:0]) * (SPLIT+CFG_W)'(iw);
  end

  // stage 4: scaled distance and range test
  assign yfull = {ph3, SPLIT'(0)} + (S_W+CFG_W)'(pl3);
  assign y_hi  = yfull[S_W+CFG_W-1:Y_SHIFT];

  always_ff @(posedge clk) begin
    y4   <= y_hi[Y_W-1:0];
    far4 <= y_hi >= (S_W+CFG_W-Y_SHIFT)'(FAR_LIM);
  end

  // stage 5: kernel index, division by the cell count
  assign kprod = (Y_W+KM_W)'(y4) * (Y_W+KM_W)'(KM);

  always_ff @(posedge clk) begin
    k5   <= kprod[KS+7:KS];
    far5 <= far4;
  end

  // stage 6: gaussian weight
  always_ff @(posedge clk) begin
    w6 <= far5 ? '0 : GAUSS_TAB[k5];
  end

  // stage 7: weight times entry, or weight times learning rate
  always_ff @(posedge clk) begin
    prod7 <= $signed({1'b0, w6}) * rd_p[6];
    wl7   <= 32'(w6) * 32'(lr);
    w7    <= w6;
  end

  // stage 8: error times scaled weight
  always_ff @(posedge clk) begin
    dprod8 <= 65'(err_q) * $signed({1'b0, wl7});
  end

  // stage 7 accumulate for queries
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      acc  <= '0;
      accw <= '0;
    end else if (v[7] && (upd_q == CMD_QUERY)) begin
      acc  <= acc + NUM_W'(prod7);
      accw <= accw + DEN_W'(w7);
    end
  end

  // write-back: delta truncated toward zero, saturated sum
  always_comb begin
    delta = dprod8[64:32];
    if (dprod8[64] && (dprod8[31:0] != 32'd0)) begin
      delta = delta + 33'sd1;
    end
    sum_new = 34'(rd_p[8]) + 34'(delta);
    if (sum_new > 34'sd2147483647) begin
      new_val = 32'sh7FFF_FFFF;
    end else if (sum_new < -34'sd2147483648) begin
      new_val = 32'sh8000_0000;
    end else begin
      new_val = sum_new[31:0];
    end
    mem_we = cmd.clr_we | (v[8] & (upd_q == CMD_UPDATE));
    waddr  = cmd.clr_we ? cmd.clr_addr : addr_p[8];
    wdata  = cmd.clr_we ? '0 : new_val;
  end

  // weight tables, second table above the first; read data pipeline
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    rd_p[1] <= mem[raddr];
    for (int s = 2; s <= 8; s++) begin
      rd_p[s] <= rd_p[s-1];
    end
  end

  // final division
  rbfe_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (acc),
    .den   (accw + DEN_W'(1)),
    .done  (stat.div_done),
    .quo   (quo)
  );

  // result register
  assign cidx = IDX_W'(row) * IDX_W'(GRID_SIDE) + IDX_W'(col);

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      ff_value   <= quo;
      cell_index <= cidx[CELL_W-1:0];
    end
  end

endmodule

// ----- rtl/core/rbfe_ctrl.sv -----
// ----------------------------------------------------------------------------
// rbfe_ctrl: controller of the rbf grid estimator
// Clears the tables after reset, takes one item, walks the neighbourhood,
// drains the pipeline; for a query it divides and loads the result register.
// ----------------------------------------------------------------------------
module rbfe_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic                 item_upd,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output rbfe_pkg::dp_cmd_t    cmd,
  input  rbfe_pkg::dp_stat_t   stat
);
  import rbfe_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_QPROD,
    ST_QROW,
    ST_ISSUE,
    ST_DRAIN,
    ST_DIVIDE,
    ST_FINISH
  } state_t;

  state_t            state;
  logic [NB_W-1:0]   ci;
  logic [NB_W-1:0]   cj;
  logic [3:0]        drain_cnt;
  logic [ADDR_W-1:0] clr_addr;
  logic              upd;

  assign s_axis_tready = (state == ST_IDLE);

  // commands to the datapath
  always_comb begin
    cmd           = '0;
    cmd.load      = (state == ST_IDLE) && s_axis_tvalid;
    cmd.issue     = (state == ST_ISSUE);
    cmd.ni        = ci;
    cmd.nj        = cj;
    cmd.div_start = (state == ST_DRAIN) && (drain_cnt == 4'(PIPE_DEPTH - 1)) &&
                    (upd == CMD_QUERY);
    cmd.out_load  = (state == ST_FINISH) && (!m_axis_tvalid || m_axis_tready);
    cmd.clr_we    = (state == ST_CLEAR);
    cmd.clr_addr  = clr_addr;
  end

  // state, counters and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLEAR;
      ci            <= '0;
      cj            <= '0;
      drain_cnt     <= '0;
      clr_addr      <= '0;
      upd           <= CMD_QUERY;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cmd.out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == ADDR_W'(MEM_DEPTH - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            upd   <= item_upd;
            state <= ST_QPROD;
          end
        end
        ST_QPROD: begin
          state <= ST_QROW;
        end
        ST_QROW: begin
          ci    <= '0;
          cj    <= '0;
          state <= ST_ISSUE;
        end
        ST_ISSUE: begin
          if (cj == NB_W'(NBHD - 1)) begin
            cj <= '0;
            ci <= ci + 1'b1;
            if (ci == NB_W'(NBHD - 1)) begin
              drain_cnt <= '0;
              state     <= ST_DRAIN;
            end
          end else begin
            cj <= cj + 1'b1;
          end
        end
        ST_DRAIN: begin
          drain_cnt <= drain_cnt + 1'b1;
          if (drain_cnt == 4'(PIPE_DEPTH - 1)) begin
            state <= (upd == CMD_UPDATE) ? ST_IDLE : ST_DIVIDE;
          end
        end
        ST_DIVIDE: begin
          if (stat.div_done) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/core/rbf_grid_feedforward_estimator.sv -----
// ----------------------------------------------------------------------------
// rbf_grid_feedforward_estimator: gaussian rbf feed-forward estimator
// Two 36x36 learned weight tables over a joint-angle grid; a query returns
// the kernel-weighted average of a 5x5 neighbourhood, an update trains it.
// ----------------------------------------------------------------------------
// After reset the block clears both weight tables to zero with
// s_axis_tready low; configuration writes are taken during that
// time. Items are handled one at a time: a query goes from accept to
// result through angle quantization (ST_QPROD, ST_QROW), the 25-cell
// neighbourhood walk, one cell per cycle, through the single table port,
// the pipeline drain, 16 radix-4 divider steps and the load of the result;
// an update skips the divider and gives no result. A finished result waits
// in the output register while the next item is accepted.
module rbf_grid_feedforward_estimator (
  input  logic                               clk,
  input  logic                               rst,
  // angle_a [15:0], angle_b [30:16], err [62:31], zero [63]
  input  logic [rbfe_pkg::S_TDATA_W-1:0]     s_axis_tdata,
  // cmd [0], table_select [1]
  input  logic [rbfe_pkg::S_TUSER_W-1:0]     s_axis_tuser,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // ff_value [31:0], cell_index [42:32], zero [47:43]
  output logic [rbfe_pkg::M_TDATA_W-1:0]     m_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  input  logic                               cfg_we,
  input  logic [rbfe_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rbfe_pkg::CFG_W-1:0]         cfg_wdata
);
  import rbfe_pkg::*;

  dp_cmd_t                cmd;
  dp_stat_t               stat;
  logic signed [FF_W-1:0] ff_value;
  logic [CELL_W-1:0]      cell_index;

  // controller
  rbfe_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .item_upd      (s_axis_tuser[0]),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cmd           (cmd),
    .stat          (stat)
  );

  // datapath
  rbfe_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_upd          (s_axis_tuser[0]),
    .in_angle_a      (s_axis_tdata[15:0]),
    .in_angle_b      (s_axis_tdata[30:16]),
    .in_table_select (s_axis_tuser[1]),
    .in_err          (s_axis_tdata[62:31]),
    .cmd             (cmd),
    .stat            (stat),
    .ff_value        (ff_value),
    .cell_index      (cell_index)
  );

  assign m_axis_tdata = {(M_TDATA_W - FF_W - CELL_W)'(0), cell_index, ff_value};

  // a result is never loaded over one that has not been taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!m_axis_tvalid || m_axis_tready))
    else $error("result register overwritten");

  // clearing and neighbour walk never overlap
  a_clear_excl: assert property (@(posedge clk) disable iff (rst)
    !(cmd.clr_we && cmd.issue))
    else $error("clear pass overlaps item work");

  // an accepted item keeps the input closed in the next cycle
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> !s_axis_tready)
    else $error("second item accepted while busy");

endmodule
